/* sv/dshl_pkg.sv */
package dshl_pkg;

  // ring geometry
  localparam int HISTORY_DEPTH = 64;
  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CE_W  = CNT_W + 1;

  // field widths
  localparam int RAW_W   = 12;
  localparam int PCT_W   = 7;
  localparam int TIME_W  = 32;
  localparam int THR_W   = 7;
  localparam int HB_W    = 16;
  localparam int LIM_W   = 7;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // scaler widths: (raw - dry) * 100 fits 19 bits, quotient below 128 after the clamp test
  localparam int NUM_W     = 19;
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = 3;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // reset values of the registers
  localparam logic [RAW_W-1:0] RAW_DRY_RST = 12'd50;
  localparam logic [RAW_W-1:0] RAW_WET_RST = 12'd2500;
  localparam logic [THR_W-1:0] THR_RST     = 7'd5;
  localparam logic [HB_W-1:0]  HB_RST      = 16'd720;
  localparam logic [HB_W-1:0]  QUIET_MAX   = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAW_DRY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_WET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 2'd3;

  // opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DECIDE,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_EMPTY
  } ctrl_state_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_CMP,
    SC_DIV,
    SC_DONE
  } scale_state_t;

  typedef struct packed {
    logic [PCT_W-1:0]  level;
    logic [TIME_W-1:0] stamp;
  } ring_entry_t;

  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    ring_entry_t       data;
  } ring_wr_t;

endpackage

/* sv/deadband_sample_history_logger.sv */
// report-by-exception level logger: a sample word scales a 12-bit reading to 0..100 percent
// between the dry and wet points (truncated, clamped, 0 when wet is not above dry) and stores
// percent and timestamp in a ring when nothing is stored yet, when the change from the last
// stored percent reaches the threshold, or when the heartbeat count of unstored samples is
// reached; a read word returns the newest min(stored, read_limit) entries oldest first, or
// one empty word. one word is in work at a time. a sample result is loaded once the
// bit-serial divider in the scaler has finished (one quotient bit per cycle, seven bits after
// a clamp test; a reading that clamps or scales to zero skips the divider), and the next word
// can be taken in the cycle after that load. a read steps through an issue state and a wait
// state for each entry, set by the registered read port of the history ram; an empty read
// loads its word from the empty state. a stalled result holds the controller in place. a new
// word is taken while the last result still waits in the output register. registers are to
// be written only while idle; the block itself does not enforce this
module deadband_sample_history_logger (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [dshl_pkg::RAW_W-1:0]      in_raw_sample,
  input  logic [dshl_pkg::TIME_W-1:0]     in_time_seconds,
  input  logic [dshl_pkg::LIM_W-1:0]      in_read_limit,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dshl_pkg::KIND_W-1:0]     out_result_kind,
  output logic [dshl_pkg::PCT_W-1:0]      out_level_percent,
  output logic                            out_was_recorded,
  output logic [dshl_pkg::PCT_W-1:0]      out_change_amount,
  output logic [dshl_pkg::TIME_W-1:0]     out_entry_time,
  output logic [dshl_pkg::LIM_W-1:0]      out_stored_entries,
  output logic                            out_last_of_run,

  input  logic                            cfg_we,
  input  logic [dshl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dshl_pkg::CFG_W-1:0]      cfg_wdata
);
  import dshl_pkg::*;

  // configuration
  logic [RAW_W-1:0] raw_dry_r;
  logic [RAW_W-1:0] raw_wet_r;
  logic [THR_W-1:0] thr_r;
  logic [HB_W-1:0]  hb_r;

  // logger state
  logic [PTR_W-1:0] wp_r;
  logic [CNT_W-1:0] valid_count_r;
  logic [PCT_W-1:0] ref_level_r;
  logic [HB_W-1:0]  quiet_r;
  logic             have_ref_r;

  ctrl_state_t state_r, state_nxt;

  // word in work
  logic [PCT_W-1:0]  pct_r;
  logic [TIME_W-1:0] time_r;
  logic [PTR_W-1:0]  rd_addr_r;
  logic [CNT_W-1:0]  rd_left_r;

  // output register
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [PCT_W-1:0]  out_level_r;
  logic              out_rec_r;
  logic [PCT_W-1:0]  out_change_r;
  logic [TIME_W-1:0] out_time_r;
  logic [LIM_W-1:0]  out_stored_r;
  logic              out_last_r;

  // control strobes
  logic accept;
  logic scale_start;
  logic rd_en;
  logic out_free;
  logic out_load;
  logic commit;

  // scaler and ring
  logic        scale_done;
  logic [PCT_W-1:0] scale_pct;
  ring_wr_t    ring_wr;
  ring_entry_t ring_rd;

  // decision on the sample in work
  logic [HB_W-1:0]  quiet_inc;
  logic [PCT_W-1:0] diff;
  logic             rec;
  logic [CNT_W-1:0] valid_count_nxt;
  logic [PTR_W-1:0] wp_inc;

  // read setup
  logic [LIM_W-1:0] valid_ext;
  logic [CNT_W-1:0] rd_count;
  logic [CE_W-1:0]  wp_ce;
  logic [CE_W-1:0]  cnt_ce;
  logic [PTR_W-1:0] rd_start;
  logic [PTR_W-1:0] rd_addr_inc;
  logic             rd_last;

  dshl_scaler u_scaler (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scale_start),
    .raw     (in_raw_sample),
    .raw_dry (raw_dry_r),
    .raw_wet (raw_wet_r),
    .done    (scale_done),
    .pct     (scale_pct)
  );

  dshl_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (ring_rd)
  );

  // quiet count saturates, first sample always records
  always_comb begin
    quiet_inc = (quiet_r == QUIET_MAX) ? quiet_r : quiet_r + 1'b1;
    if (!have_ref_r) diff = PCT_MAX;
    else if (pct_r >= ref_level_r) diff = pct_r - ref_level_r;
    else diff = ref_level_r - pct_r;
    rec = !have_ref_r || (diff >= thr_r) || (quiet_inc >= hb_r);
    if (rec && (valid_count_r != CNT_W'(HISTORY_DEPTH))) valid_count_nxt = valid_count_r + 1'b1;
    else valid_count_nxt = valid_count_r;
    wp_inc = (wp_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  end

  // newest entries end just below the write pointer
  always_comb begin
    valid_ext = LIM_W'(valid_count_r);
    rd_count  = (in_read_limit < valid_ext) ? CNT_W'(in_read_limit) : valid_count_r;
    wp_ce     = CE_W'(wp_r);
    cnt_ce    = CE_W'(rd_count);
    if (wp_ce >= cnt_ce) rd_start = PTR_W'(wp_ce - cnt_ce);
    else rd_start = PTR_W'(wp_ce + CE_W'(HISTORY_DEPTH) - cnt_ce);
    rd_addr_inc = (rd_addr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_r + 1'b1;
    rd_last     = (rd_left_r == CNT_W'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_SAMPLE) state_nxt = ST_SCALE;
          else if (rd_count == '0) state_nxt = ST_EMPTY;
          else state_nxt = ST_RD_ISSUE;
        end
      end
      ST_SCALE:    if (scale_done) state_nxt = ST_DECIDE;
      ST_DECIDE:   if (out_free) state_nxt = ST_IDLE;
      ST_RD_ISSUE: state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (out_free) state_nxt = rd_last ? ST_IDLE : ST_RD_ISSUE;
      end
      ST_EMPTY:    if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free    = !out_valid_r || out_ready;
    in_ready    = (state_r == ST_IDLE);
    accept      = in_valid && in_ready;
    scale_start = accept && (in_opcode == OP_SAMPLE);
    rd_en       = (state_r == ST_RD_ISSUE);
    commit      = (state_r == ST_DECIDE) && out_free;
    out_load    = out_free && ((state_r == ST_DECIDE) || (state_r == ST_RD_WAIT) ||
                               (state_r == ST_EMPTY));
  end

  always_comb begin
    ring_wr.en         = commit && rec;
    ring_wr.addr       = wp_r;
    ring_wr.data.level = pct_r;
    ring_wr.data.stamp = time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_dry_r <= RAW_DRY_RST;
      raw_wet_r <= RAW_WET_RST;
      thr_r     <= THR_RST;
      hb_r      <= HB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAW_DRY:   raw_dry_r <= cfg_wdata[RAW_W-1:0];
        REG_RAW_WET:   raw_wet_r <= cfg_wdata[RAW_W-1:0];
        REG_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        REG_HEARTBEAT: hb_r      <= cfg_wdata[HB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wp_r          <= '0;
      valid_count_r <= '0;
      ref_level_r   <= '0;
      quiet_r       <= '0;
      have_ref_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        valid_count_r <= valid_count_nxt;
        if (rec) begin
          wp_r        <= wp_inc;
          ref_level_r <= pct_r;
          have_ref_r  <= 1'b1;
          quiet_r     <= '0;
        end else begin
          quiet_r <= quiet_inc;
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath of the word in work
  always_ff @(posedge clk) begin
    if (accept) begin
      time_r    <= in_time_seconds;
      rd_addr_r <= rd_start;
      rd_left_r <= rd_count;
    end
    if ((state_r == ST_SCALE) && scale_done) pct_r <= scale_pct;
    if ((state_r == ST_RD_WAIT) && out_free) begin
      rd_addr_r <= rd_addr_inc;
      rd_left_r <= rd_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (state_r)
        ST_DECIDE: begin
          out_kind_r   <= KIND_STATUS;
          out_level_r  <= pct_r;
          out_rec_r    <= rec;
          out_change_r <= diff;
          out_time_r   <= time_r;
          out_stored_r <= LIM_W'(valid_count_nxt);
          out_last_r   <= 1'b1;
        end
        ST_RD_WAIT: begin
          out_kind_r   <= KIND_ENTRY;
          out_level_r  <= ring_rd.level;
          out_rec_r    <= 1'b0;
          out_change_r <= '0;
          out_time_r   <= ring_rd.stamp;
          out_stored_r <= LIM_W'(valid_count_r);
          out_last_r   <= rd_last;
        end
        default: begin
          out_kind_r   <= KIND_EMPTY;
          out_level_r  <= '0;
          out_rec_r    <= 1'b0;
          out_change_r <= '0;
          out_time_r   <= '0;
          out_stored_r <= LIM_W'(valid_count_r);
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_level_percent  = out_level_r;
  assign out_was_recorded   = out_rec_r;
  assign out_change_amount  = out_change_r;
  assign out_entry_time     = out_time_r;
  assign out_stored_entries = out_stored_r;
  assign out_last_of_run    = out_last_r;

`ifndef ASSERT_OFF
  // the scaler only finishes while the controller waits for it
  a_done_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
    scale_done |-> (state_r == ST_SCALE))
    else $error("scaler finished outside the scale state");

  // a recorded sample sets the reference and clears the quiet count
  a_rec_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && rec) |=> (have_ref_r && (quiet_r == '0) && (valid_count_r != '0)))
    else $error("recording did not update the reference state");

  // no reference yet means nothing stored
  a_empty_no_ref: assert property (@(posedge clk) disable iff (!rst_n)
    !have_ref_r |-> ((valid_count_r == '0) && (wp_r == '0)))
    else $error("ring holds entries without a reference");

  // ring fill never exceeds its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (valid_count_r <= CNT_W'(HISTORY_DEPTH)))
    else $error("ring fill count above depth");
`endif

endmodule

/* sv/dshl_scaler.sv */
module dshl_scaler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dshl_pkg::RAW_W-1:0] raw,
  input  logic [dshl_pkg::RAW_W-1:0] raw_dry,
  input  logic [dshl_pkg::RAW_W-1:0] raw_wet,
  output logic                       done,
  output logic [dshl_pkg::PCT_W-1:0] pct
);
  import dshl_pkg::*;

  scale_state_t state_r, state_nxt;

  logic [RAW_W-1:0]  d_r;
  logic [RAW_W-1:0]  span_r;
  logic              zero_r;
  logic [NUM_W-1:0]  num_r;
  logic [RAW_W-1:0]  rem_r;
  logic [PCT_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;

  logic [RAW_W:0]    trial;
  logic              trial_ge;
  logic [NUM_W-1:0]  d_ext;
  logic [NUM_W-1:0]  span_top;

  // one quotient bit per cycle: shift a numerator bit into the remainder
  assign trial    = {rem_r, q_r[PCT_W-1]};
  assign trial_ge = trial >= {1'b0, span_r};
  assign d_ext    = NUM_W'(d_r);
  assign span_top = {span_r, 7'b0};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SC_IDLE: if (start) state_nxt = SC_MUL;
      SC_MUL:  state_nxt = SC_CMP;
      SC_CMP: begin
        if (zero_r || (num_r >= span_top)) state_nxt = SC_DONE;
        else state_nxt = SC_DIV;
      end
      SC_DIV:  if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = SC_DONE;
      SC_DONE: state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == SC_DONE);
    pct  = (q_r > PCT_MAX) ? PCT_MAX : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SC_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          d_r    <= raw - raw_dry;
          span_r <= raw_wet - raw_dry;
          zero_r <= (raw_wet <= raw_dry) || (raw <= raw_dry);
        end
      end
      SC_MUL: begin
        // times 100 as 64 + 32 + 4
        num_r <= (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
      end
      SC_CMP: begin
        step_r <= '0;
        if (zero_r) begin
          q_r <= '0;
        end else if (num_r >= span_top) begin
          q_r <= PCT_MAX;
        end else begin
          rem_r <= num_r[NUM_W-1:DIV_STEPS];
          q_r   <= num_r[DIV_STEPS-1:0];
        end
      end
      SC_DIV: begin
        step_r <= step_r + 1'b1;
        q_r    <= {q_r[PCT_W-2:0], trial_ge};
        if (trial_ge) rem_r <= RAW_W'(trial - {1'b0, span_r});
        else rem_r <= trial[RAW_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/dshl_ring.sv */
module dshl_ring (
  input  logic                       clk,
  input  dshl_pkg::ring_wr_t         wr,
  input  logic                       rd_en,
  input  logic [dshl_pkg::PTR_W-1:0] rd_addr,
  output dshl_pkg::ring_entry_t      rd_data
);
  import dshl_pkg::*;

  logic [PCT_W-1:0]  level_mem [HISTORY_DEPTH];
  logic [TIME_W-1:0] time_mem  [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      level_mem[wr.addr] <= wr.data.level;
      time_mem[wr.addr]  <= wr.data.stamp;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.level <= level_mem[rd_addr];
      rd_data.stamp <= time_mem[rd_addr];
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  import dshl_pkg::*;

  // run length and limits
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 30;

  // one result word, as seen on the out_ channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PCT_W-1:0]  level;
    logic              rec;
    logic [PCT_W-1:0]  change;
    logic [TIME_W-1:0] stamp;
    logic [LIM_W-1:0]  stored;
    logic              last;
  } log_word_t;

  // directed table rows
  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_READ} row_act_t;

  typedef struct {
    row_act_t    act;
    int          arg;      // register index, raw reading or read limit
    logic [31:0] val;      // register value or timestamp
    bit          chk;      // expected word typed in below
    int          w_level;
    int          w_rec;
    int          w_change;
    int          w_stored;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_opcode;
  logic [RAW_W-1:0]     in_raw_sample;
  logic [TIME_W-1:0]    in_time_seconds;
  logic [LIM_W-1:0]     in_read_limit;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    out_result_kind;
  logic [PCT_W-1:0]     out_level_percent;
  logic                 out_was_recorded;
  logic [PCT_W-1:0]     out_change_amount;
  logic [TIME_W-1:0]    out_entry_time;
  logic [LIM_W-1:0]     out_stored_entries;
  logic                 out_last_of_run;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  deadband_sample_history_logger i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_raw_sample      (in_raw_sample),
    .in_time_seconds    (in_time_seconds),
    .in_read_limit      (in_read_limit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_level_percent  (out_level_percent),
    .out_was_recorded   (out_was_recorded),
    .out_change_amount  (out_change_amount),
    .out_entry_time     (out_entry_time),
    .out_stored_entries (out_stored_entries),
    .out_last_of_run    (out_last_of_run),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // shadow copy of the logger: calibration, ring and deadband state
  int                dry_pt, wet_pt, thr_pct, hb_count;
  logic [PCT_W-1:0]  ring_level [HISTORY_DEPTH];
  logic [TIME_W-1:0] ring_stamp [HISTORY_DEPTH];
  int                wr_ptr, n_stored, ref_level, quiet_count;
  bit                have_ref;

  // words predicted for the last accepted input, and words still owed by the block
  log_word_t predicted_words[$];
  log_word_t expected_log_words[$];
  stim_row_t stim_rows[$];

  // bookkeeping
  int fail_count     = 0;
  int words_checked  = 0;
  int samples_sent   = 0;
  int reads_sent     = 0;
  int samples_stored = 0;
  int settings_used  = 0;
  int cycle_count    = 0;
  int idle_pct       = 0;
  int ready_hold     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t run stopped at the cycle limit, %0d words still owed", $time,
               expected_log_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure: random bursts of low ready
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
      ready_hold = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // percent between the dry and wet points, truncated and clamped
  function automatic int level_of(input logic [RAW_W-1:0] raw);
    int r;
    int pct;
    r = int'(raw);
    if (wet_pt <= dry_pt || r <= dry_pt) return 0;
    pct = ((r - dry_pt) * 100) / (wet_pt - dry_pt);
    return (pct > int'(PCT_MAX)) ? int'(PCT_MAX) : pct;
  endfunction

  // shadow state after reset
  task automatic reset_logger_model();
    dry_pt      = int'(RAW_DRY_RST);
    wet_pt      = int'(RAW_WET_RST);
    thr_pct     = int'(THR_RST);
    hb_count    = int'(HB_RST);
    wr_ptr      = 0;
    n_stored    = 0;
    ref_level   = 0;
    quiet_count = 0;
    have_ref    = 1'b0;
  endtask

  // works out the result words of one input word and advances the shadow state
  task automatic predict_log_word(input logic op, input logic [RAW_W-1:0] raw,
                                  input logic [TIME_W-1:0] stamp,
                                  input logic [LIM_W-1:0] lim);
    log_word_t w;
    int        pct, diff, n, first, i;
    bit        store;
    predicted_words.delete();
    w = '0;
    if (op == OP_SAMPLE) begin
      pct = level_of(raw);
      if (quiet_count < int'(QUIET_MAX)) quiet_count++;
      // nothing stored yet counts as a full-scale change
      if (!have_ref) diff = 100;
      else diff = (pct >= ref_level) ? pct - ref_level : ref_level - pct;
      store = !have_ref || diff >= thr_pct || quiet_count >= hb_count;
      if (store) begin
        ring_level[wr_ptr] = PCT_W'(pct);
        ring_stamp[wr_ptr] = stamp;
        wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
        if (n_stored < HISTORY_DEPTH) n_stored++;
        ref_level   = pct;
        have_ref    = 1'b1;
        quiet_count = 0;
        samples_stored++;
      end
      w.kind   = KIND_STATUS;
      w.level  = PCT_W'(pct);
      w.rec    = store;
      w.change = PCT_W'(diff);
      w.stamp  = stamp;
      w.stored = LIM_W'(n_stored);
      w.last   = 1'b1;
      predicted_words.push_back(w);
    end else begin
      n = (int'(lim) < n_stored) ? int'(lim) : n_stored;
      if (n == 0) begin
        w.kind   = KIND_EMPTY;
        w.stored = LIM_W'(n_stored);
        w.last   = 1'b1;
        predicted_words.push_back(w);
      end else begin
        // newest n entries, oldest first
        first = (wr_ptr + HISTORY_DEPTH - n) % HISTORY_DEPTH;
        for (i = 0; i < n; i++) begin
          w.kind   = KIND_ENTRY;
          w.level  = ring_level[(first + i) % HISTORY_DEPTH];
          w.stamp  = ring_stamp[(first + i) % HISTORY_DEPTH];
          w.stored = LIM_W'(n_stored);
          w.last   = (i == n - 1);
          predicted_words.push_back(w);
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // every accepted result word is held against the oldest expectation
  always @(posedge clk) begin
    log_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_log_words.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result word: expected none, actual kind %0d level %0d",
                 $time, out_result_kind, out_level_percent);
      end else begin
        want = expected_log_words.pop_front();
        words_checked++;
        compare_field("result_kind", 32'(want.kind), 32'(out_result_kind));
        compare_field("level_percent", 32'(want.level), 32'(out_level_percent));
        compare_field("was_recorded", 32'(want.rec), 32'(out_was_recorded));
        compare_field("change_amount", 32'(want.change), 32'(out_change_amount));
        compare_field("entry_time", want.stamp, out_entry_time);
        compare_field("stored_entries", 32'(want.stored), 32'(out_stored_entries));
        compare_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
      end
    end
  end

  // lower the input side for an idle stretch of the given length
  task automatic hold_off(input int n);
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // register write, only once the block has delivered everything it owes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_log_words.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RAW_DRY:   dry_pt   = int'(val[RAW_W-1:0]);
      REG_RAW_WET:   wet_pt   = int'(val[RAW_W-1:0]);
      REG_THRESHOLD: thr_pct  = int'(val[THR_W-1:0]);
      REG_HEARTBEAT: hb_count = int'(val[HB_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // presents one input word and waits for it to be taken
  task automatic send_word(input logic op, input logic [RAW_W-1:0] raw,
                           input logic [TIME_W-1:0] stamp, input logic [LIM_W-1:0] lim,
                           input bit typed, input log_word_t typed_word);
    cfg_we          <= 1'b0;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_raw_sample   <= raw;
    in_time_seconds <= stamp;
    in_read_limit   <= lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_log_word(op, raw, stamp, lim);
    // typed rows still advance the shadow state; their expectation is the typed one
    if (typed) expected_log_words.push_back(typed_word);
    else foreach (predicted_words[k]) expected_log_words.push_back(predicted_words[k]);
    if (op == OP_SAMPLE) samples_sent++;
    else reads_sent++;
  endtask

  function automatic void add_row(input row_act_t act, input int arg, input logic [31:0] val,
                                  input bit chk, input int lvl, input int rec,
                                  input int chg, input int cnt);
    stim_row_t row;
    row.act      = act;
    row.arg      = arg;
    row.val      = val;
    row.chk      = chk;
    row.w_level  = lvl;
    row.w_rec    = rec;
    row.w_change = chg;
    row.w_stored = cnt;
    stim_rows.push_back(row);
  endfunction

  // directed table; rows with chk set carry the expected status or empty word
  function automatic void load_directed_table();
    //      action      arg            value           chk lvl rec chg cnt
    // empty ring right after reset
    add_row(ROW_READ,   5,             0,              1,  0,  0,  0,  0);
    // first sample at the top of the converter range: clamped, always stored
    add_row(ROW_SAMPLE, 4095,          32'h0000_0000,  1,  100, 1, 100, 1);
    add_row(ROW_SAMPLE, 0,             32'hFFFF_FFFF,  1,  0,  1,  100, 2);
    // reading exactly at dry, no change from the last stored level
    add_row(ROW_SAMPLE, 50,            32'h1234_5678,  1,  0,  0,  0,  2);
    add_row(ROW_SAMPLE, 2500,          32'h8000_0000,  1,  100, 1, 100, 3);
    add_row(ROW_SAMPLE, 51,            32'h5555_5555,  0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 1275,          32'hAAAA_AAAA,  0,  0,  0,  0,  0);
    // inside the deadband
    add_row(ROW_SAMPLE, 1300,          32'h0000_0E10,  0,  0,  0,  0,  0);
    // read limit zero gives one empty word
    add_row(ROW_READ,   0,             0,              1,  0,  0,  0,  5);
    // limit above the stored count, then a partial read
    add_row(ROW_READ,   127,           0,              0,  0,  0,  0,  0);
    add_row(ROW_READ,   2,             0,              0,  0,  0,  0,  0);
    // zero threshold stores even an unchanged level
    add_row(ROW_CFG,    REG_THRESHOLD, 0,              0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 1275,          32'h0000_1C20,  0,  0,  0,  0,  0);
    // threshold above 100: only the heartbeat can store
    add_row(ROW_CFG,    REG_THRESHOLD, 127,            0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 4095,          32'h0000_2A30,  0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_HEARTBEAT, 3,              0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 0,             32'h0000_3840,  0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 0,             32'h0000_4650,  0,  0,  0,  0,  0);
    // heartbeat zero and one store every sample
    add_row(ROW_CFG,    REG_HEARTBEAT, 0,              0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 2047,          32'h0000_5460,  0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_HEARTBEAT, 1,              0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 2047,          32'h0000_6270,  0,  0,  0,  0,  0);
    // wet equal to dry, then wet below dry: level stays at zero
    add_row(ROW_CFG,    REG_RAW_DRY,   2000,           0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_RAW_WET,   2000,           0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 4095,          32'h0000_7080,  0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_RAW_DRY,   4095,           0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_RAW_WET,   0,              0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 4095,          32'h0000_7E90,  0,  0,  0,  0,  0);
    // full converter span, widest heartbeat
    add_row(ROW_CFG,    REG_RAW_DRY,   0,              0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_RAW_WET,   4095,           0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_THRESHOLD, 5,              0,  0,  0,  0,  0);
    add_row(ROW_CFG,    REG_HEARTBEAT, 65535,          0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 4095,          32'h0000_8CA0,  0,  0,  0,  0,  0);
    add_row(ROW_SAMPLE, 2047,          32'h0000_9AB0,  0,  0,  0,  0,  0);
    add_row(ROW_READ,   64,            0,              0,  0,  0,  0,  0);
  endfunction

  // walks the directed table
  task automatic run_directed_table();
    log_word_t typed_word;
    stim_row_t row;
    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      typed_word        = '0;
      typed_word.kind   = (row.act == ROW_READ) ? KIND_EMPTY : KIND_STATUS;
      typed_word.level  = PCT_W'(row.w_level);
      typed_word.rec    = 1'(row.w_rec);
      typed_word.change = PCT_W'(row.w_change);
      typed_word.stamp  = (row.act == ROW_READ) ? 32'd0 : row.val;
      typed_word.stored = LIM_W'(row.w_stored);
      typed_word.last   = 1'b1;
      if (row.act != ROW_CFG && $urandom_range(0, 99) < idle_pct)
        hold_off($urandom_range(1, 19));
      case (row.act)
        ROW_CFG:    write_reg(CFG_IDX_W'(row.arg), CFG_W'(row.val));
        ROW_SAMPLE: send_word(OP_SAMPLE, RAW_W'(row.arg), row.val, '0, row.chk, typed_word);
        default:    send_word(OP_READ, '0, '0, LIM_W'(row.arg), row.chk, typed_word);
      endcase
    end
  endtask

  // one random calibration setting followed by a run of random words
  task automatic run_random_phase(input int n_words, input int idle_rate);
    log_word_t   none;
    int          dry, wet, thr, hb, raw, lo, hi, w;
    logic [31:0] t_now;
    none = '0;
    case ($urandom_range(0, 7))
      0:       dry = 0;
      1:       dry = 4095;
      default: dry = $urandom_range(0, 1500);
    endcase
    case ($urandom_range(0, 7))
      0:       wet = 4095;
      1:       wet = dry;
      2:       wet = $urandom_range(0, dry);
      default: wet = dry + $urandom_range(20, 2500);
    endcase
    if (wet > 4095) wet = 4095;
    case ($urandom_range(0, 5))
      0:       thr = 0;
      1:       thr = $urandom_range(101, 127);
      default: thr = $urandom_range(1, 15);
    endcase
    case ($urandom_range(0, 5))
      0:       hb = $urandom_range(0, 1);
      1:       hb = 65535;
      2:       hb = $urandom_range(2, 8);
      default: hb = $urandom_range(9, 40);
    endcase
    write_reg(REG_RAW_DRY, CFG_W'(dry));
    write_reg(REG_RAW_WET, CFG_W'(wet));
    write_reg(REG_THRESHOLD, CFG_W'(thr));
    write_reg(REG_HEARTBEAT, CFG_W'(hb));
    settings_used++;
    idle_pct = idle_rate;
    // readings wander around the calibrated span so the deadband is crossed both ways
    lo    = (dry > 100) ? dry - 100 : 0;
    hi    = (wet > dry) ? wet + 100 : dry + 400;
    if (hi > 4095) hi = 4095;
    if (lo > hi) lo = hi;
    raw   = $urandom_range(lo, hi);
    t_now = $urandom;
    for (w = 0; w < n_words; w++) begin
      if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 19));
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       send_word(OP_READ, RAW_W'($urandom_range(0, 4095)), $urandom, '0,
                             1'b0, none);
          1:       send_word(OP_READ, RAW_W'($urandom_range(0, 4095)), $urandom,
                             LIM_W'($urandom_range(65, 127)), 1'b0, none);
          default: send_word(OP_READ, RAW_W'($urandom_range(0, 4095)), $urandom,
                             LIM_W'($urandom_range(1, 64)), 1'b0, none);
        endcase
      end else begin
        case ($urandom_range(0, 7))
          0:       raw = $urandom_range(0, 4095);
          1:       raw = raw;
          default: raw = raw + $urandom_range(0, 200) - 100;
        endcase
        if (raw < 0) raw = 0;
        if (raw > 4095) raw = 4095;
        // mostly rising uptime, now and then a jump anywhere
        if ($urandom_range(0, 7) == 0) t_now = $urandom;
        else t_now = t_now + $urandom_range(1, 600);
        send_word(OP_SAMPLE, RAW_W'(raw), t_now, LIM_W'($urandom_range(0, 127)), 1'b0, none);
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_SAMPLE;
    in_raw_sample   = '0;
    in_time_seconds = '0;
    in_read_limit   = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_RAW_DRY;
    cfg_wdata       = '0;
    reset_logger_model();
    load_directed_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 15;
    settings_used = 1;
    run_directed_table();

    // random phases; some without idling, the last one always without
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1 || p % 4 == 3) run_random_phase(PHASE_WORDS, 0);
      else run_random_phase(PHASE_WORDS, $urandom_range(5, 40));
    end

    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (expected_log_words.size() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples and %0d history reads over %0d settings, %0d words checked",
             samples_sent, reads_sent, settings_used, words_checked);
    $display("%0d samples stored, ring holds %0d of %0d entries, %0d cycles",
             samples_stored, n_stored, HISTORY_DEPTH, cycle_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
